// File: hw/rtl/kmf_pkg.sv
// shared types, constants and helper functions for the keyword mask filter
`timescale 1ns / 1ps

package kmf_pkg;

    localparam int BYTE_W              = 8;
    localparam int KW_W                = 64;
    localparam int LEN_W               = 4;
    localparam int LENS_W              = 20;
    localparam int CFG_IDX_W           = 3;
    localparam int STAT_W              = 16;
    localparam int KW_COUNT_MAX        = 5;
    localparam int DEF_NUM_KEYWORDS    = 5;
    localparam int DEF_MAX_KEYWORD_LEN = 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LENGTHS = 3'd5;

    localparam logic [KW_COUNT_MAX-1:0][KW_W-1:0] KW_RESET = {
        64'd114776364114464,
        64'd7566177,
        64'd1852662116,
        64'd1953065075,
        64'd1801680230
    };
    localparam logic [LENS_W-1:0] LENS_RESET = 20'd406596;

    localparam logic [BYTE_W-1:0] STAR_BYTE = 8'h2A;
    localparam logic [STAT_W-1:0] STAT_MAX  = 16'hFFFF;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              masked;
        logic              last;
    } kmf_entry_t;

    function automatic logic [BYTE_W-1:0] kmf_fold(input logic [BYTE_W-1:0] b);
        return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
    endfunction

    function automatic logic kmf_is_space(input logic [BYTE_W-1:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic [STAT_W-1:0] kmf_sat_inc(input logic [STAT_W-1:0] c);
        return (c == STAT_MAX) ? c : c + 16'd1;
    endfunction

endpackage

// File: hw/rtl/kmf_cfg.sv
// configuration register file: keyword bytes and keyword lengths
`timescale 1ns / 1ps

module kmf_cfg
    import kmf_pkg::*;
#(
    parameter int NUM_KEYWORDS    = DEF_NUM_KEYWORDS,
    parameter int MAX_KEYWORD_LEN = DEF_MAX_KEYWORD_LEN
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]                  cfg_index,
    input  logic [KW_W-1:0]                       cfg_data,
    output logic [NUM_KEYWORDS-1:0][KW_W-1:0]     kw_words,
    output logic [NUM_KEYWORDS-1:0][LEN_W-1:0]    kw_lens
);

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_KEYWORD_LEN);

    logic [NUM_KEYWORDS-1:0][KW_W-1:0] kw_reg;
    logic [NUM_KEYWORDS-1:0][KW_W-1:0] kw_next;
    logic [LENS_W-1:0]                 lens_reg;
    logic [LENS_W-1:0]                 lens_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        kw_next   = kw_reg;
        lens_next = lens_reg;
        if (cfg_valid) begin
            for (int k = 0; k < NUM_KEYWORDS; k++) begin
                if (cfg_index == CFG_IDX_W'(k)) begin
                    kw_next[k] = cfg_data;
                end
            end
            if (cfg_index == CFG_IDX_LENGTHS) begin
                lens_next = cfg_data[LENS_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_KEYWORDS; k++) begin
                kw_reg[k] <= KW_RESET[k];
            end
            lens_reg <= LENS_RESET;
        end else begin
            kw_reg   <= kw_next;
            lens_reg <= lens_next;
        end
    end

    // lengths above the maximum saturate
    always_comb begin
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            kw_words[k] = kw_reg[k];
            kw_lens[k]  = (lens_reg[LEN_W*k +: LEN_W] > LEN_MAX) ? LEN_MAX
                                                                  : lens_reg[LEN_W*k +: LEN_W];
        end
    end

endmodule

// File: hw/rtl/kmf_front.sv
// front end: byte window, case folding and cascaded keyword matchers
`timescale 1ns / 1ps

module kmf_front
    import kmf_pkg::*;
#(
    parameter int NUM_KEYWORDS    = DEF_NUM_KEYWORDS,
    parameter int MAX_KEYWORD_LEN = DEF_MAX_KEYWORD_LEN
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [NUM_KEYWORDS-1:0][KW_W-1:0]     kw_words,
    input  logic [NUM_KEYWORDS-1:0][LEN_W-1:0]    kw_lens,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [BYTE_W-1:0]                     s_in_byte,
    input  logic                                  s_in_last,
    output logic                                  q_push,
    output kmf_entry_t                            q_entry,
    input  logic                                  q_full
);

    localparam int SPAN    = MAX_KEYWORD_LEN - 1;
    localparam int LAG     = NUM_KEYWORDS * SPAN;
    localparam int DEPTH   = LAG + 1;
    localparam int STAGE_W = $clog2(DEPTH);
    localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(LAG);

    logic [BYTE_W-1:0] raw_reg  [DEPTH];
    logic [BYTE_W-1:0] raw_next [DEPTH];
    logic [BYTE_W-1:0] fold_reg [DEPTH];
    logic [BYTE_W-1:0] fold_next[DEPTH];
    logic [BYTE_W-1:0] fold_upd [DEPTH];
    logic [DEPTH-1:0]  mask_reg;
    logic [DEPTH-1:0]  mask_next;
    logic [DEPTH-1:0]  mask_upd;
    logic [DEPTH-1:0]  valid_reg;
    logic [DEPTH-1:0]  valid_next;
    logic [DEPTH-1:0]  last_reg;
    logic [DEPTH-1:0]  last_next;
    logic [DEPTH-1:0]  move;

    logic [NUM_KEYWORDS-1:0]             fresh_reg;
    logic [NUM_KEYWORDS-1:0]             fresh_next;
    logic [NUM_KEYWORDS-1:0][LEN_W-1:0]  skip_reg;
    logic [NUM_KEYWORDS-1:0][LEN_W-1:0]  skip_next;
    logic [STAGE_W-1:0]                  open_cnt_reg;
    logic [STAGE_W-1:0]                  open_cnt_next;

    logic exit_ok;
    logic in_go;

    assign exit_ok = !valid_reg[LAG] || !q_full;
    assign s_ready = exit_ok;
    assign in_go   = s_valid && exit_ok;

    // bytes of an unfinished message hold still without input, older ones drain
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            move[i] = exit_ok && (in_go || (STAGE_W'(i) >= open_cnt_reg));
        end
    end

    // keyword matchers in priority order, each one stage span further back
    always_comb begin
        int  a;
        logic hit;
        fold_upd  = fold_reg;
        mask_upd  = mask_reg;
        skip_next = skip_reg;
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            a   = (k + 1) * SPAN;
            hit = 1'b0;
            if (fresh_reg[k] && valid_reg[STAGE_W'(a)]) begin
                if (skip_reg[k] != '0) begin
                    skip_next[k] = skip_reg[k] - LEN_W'(1);
                end else if (kw_lens[k] != '0) begin
                    hit = 1'b1;
                    for (int j = 0; j < MAX_KEYWORD_LEN; j++) begin
                        if (LEN_W'(j) < kw_lens[k] &&
                            fold_upd[STAGE_W'(a - j)] != kmf_fold(kw_words[k][BYTE_W*j +: BYTE_W])) begin
                            hit = 1'b0;
                        end
                        if (LEN_W'(j + 1) < kw_lens[k] && last_reg[STAGE_W'(a - j)]) begin
                            hit = 1'b0;
                        end
                    end
                    if (hit) begin
                        for (int j = 0; j < MAX_KEYWORD_LEN; j++) begin
                            if (LEN_W'(j) < kw_lens[k]) begin
                                mask_upd[STAGE_W'(a - j)] = 1'b1;
                                fold_upd[STAGE_W'(a - j)] = STAR_BYTE;
                            end
                        end
                        skip_next[k] = kw_lens[k] - LEN_W'(1);
                    end
                end
                if (last_reg[STAGE_W'(a)]) begin
                    skip_next[k] = '0;
                end
            end
        end
    end

    always_comb begin
        if (move[0]) begin
            raw_next[0]   = s_in_byte;
            fold_next[0]  = kmf_fold(s_in_byte);
            mask_next[0]  = 1'b0;
            valid_next[0] = in_go;
            last_next[0]  = s_in_last;
        end else begin
            raw_next[0]   = raw_reg[0];
            fold_next[0]  = fold_upd[0];
            mask_next[0]  = mask_upd[0];
            valid_next[0] = valid_reg[0];
            last_next[0]  = last_reg[0];
        end
        for (int i = 1; i < DEPTH; i++) begin
            if (move[i] && move[i-1]) begin
                raw_next[i]   = raw_reg[i-1];
                fold_next[i]  = fold_upd[i-1];
                mask_next[i]  = mask_upd[i-1];
                valid_next[i] = valid_reg[i-1];
                last_next[i]  = last_reg[i-1];
            end else if (move[i]) begin
                raw_next[i]   = raw_reg[i-1];
                fold_next[i]  = fold_upd[i-1];
                mask_next[i]  = 1'b0;
                valid_next[i] = 1'b0;
                last_next[i]  = 1'b0;
            end else begin
                raw_next[i]   = raw_reg[i];
                fold_next[i]  = fold_upd[i];
                mask_next[i]  = mask_upd[i];
                valid_next[i] = valid_reg[i];
                last_next[i]  = last_reg[i];
            end
        end
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            fresh_next[k] = move[(k + 1) * SPAN];
        end
    end

    always_comb begin
        open_cnt_next = open_cnt_reg;
        if (in_go) begin
            if (s_in_last) begin
                open_cnt_next = '0;
            end else if (open_cnt_reg != LAST_STAGE) begin
                open_cnt_next = open_cnt_reg + STAGE_W'(1);
            end
        end
    end

    assign q_push         = move[LAG] && valid_reg[LAG];
    assign q_entry.data   = mask_upd[LAG] ? STAR_BYTE : raw_reg[LAG];
    assign q_entry.masked = mask_upd[LAG];
    assign q_entry.last   = last_reg[LAG];

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            raw_reg[i]  <= raw_next[i];
            fold_reg[i] <= fold_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg     <= '0;
            valid_reg    <= '0;
            last_reg     <= '0;
            fresh_reg    <= '0;
            skip_reg     <= '0;
            open_cnt_reg <= '0;
        end else begin
            mask_reg     <= mask_next;
            valid_reg    <= valid_next;
            last_reg     <= last_next;
            fresh_reg    <= fresh_next;
            skip_reg     <= skip_next;
            open_cnt_reg <= open_cnt_next;
        end
    end

endmodule

// File: hw/rtl/kmf_queue.sv
// small fifo between the window front end and the statistics back end
`timescale 1ns / 1ps

module kmf_queue
    import kmf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  kmf_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output kmf_entry_t pop_entry,
    output logic       not_empty
);

    localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);
    localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);

    kmf_entry_t          mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_entry = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hw/rtl/kmf_back.sv
// back end: per-message statistics and the registered result stage
`timescale 1ns / 1ps

module kmf_back
    import kmf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  kmf_entry_t        q_entry,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_out_byte,
    output logic              m_out_last,
    output logic              m_filtered,
    output logic [STAT_W-1:0] m_byte_count,
    output logic [STAT_W-1:0] m_word_total
);

    logic [STAT_W-1:0] bytes_seen_reg;
    logic [STAT_W-1:0] bytes_seen_next;
    logic [STAT_W-1:0] words_seen_reg;
    logic [STAT_W-1:0] words_seen_next;
    logic              inside_word_reg;
    logic              inside_word_next;
    logic              any_masked_reg;
    logic              any_masked_next;
    logic              m_valid_reg;
    logic              m_valid_next;

    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;
    logic              filtered_reg;
    logic [STAT_W-1:0] byte_count_reg;
    logic [STAT_W-1:0] word_total_reg;

    logic [STAT_W-1:0] bytes_new;
    logic [STAT_W-1:0] words_new;
    logic              space;
    logic              any_new;

    assign q_pop = q_valid && (!m_valid_reg || m_ready);

    assign space     = kmf_is_space(q_entry.data);
    assign bytes_new = kmf_sat_inc(bytes_seen_reg);
    assign words_new = (!space && !inside_word_reg) ? kmf_sat_inc(words_seen_reg)
                                                    : words_seen_reg;
    assign any_new   = any_masked_reg || q_entry.masked;

    always_comb begin
        bytes_seen_next  = bytes_seen_reg;
        words_seen_next  = words_seen_reg;
        inside_word_next = inside_word_reg;
        any_masked_next  = any_masked_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        if (q_pop) begin
            m_valid_next = 1'b1;
            if (q_entry.last) begin
                bytes_seen_next  = '0;
                words_seen_next  = '0;
                inside_word_next = 1'b0;
                any_masked_next  = 1'b0;
            end else begin
                bytes_seen_next  = bytes_new;
                words_seen_next  = words_new;
                inside_word_next = !space;
                any_masked_next  = any_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_byte_reg   <= q_entry.data;
            out_last_reg   <= q_entry.last;
            filtered_reg   <= q_entry.last && any_new;
            byte_count_reg <= q_entry.last ? bytes_new : '0;
            word_total_reg <= q_entry.last ? words_new : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_seen_reg  <= '0;
            words_seen_reg  <= '0;
            inside_word_reg <= 1'b0;
            any_masked_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            bytes_seen_reg  <= bytes_seen_next;
            words_seen_reg  <= words_seen_next;
            inside_word_reg <= inside_word_next;
            any_masked_reg  <= any_masked_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = out_byte_reg;
    assign m_out_last   = out_last_reg;
    assign m_filtered   = filtered_reg;
    assign m_byte_count = byte_count_reg;
    assign m_word_total = word_total_reg;

endmodule

// File: hw/rtl/keyword_mask_filter.sv
// top level of the keyword mask filter
// usage:
//   input requests (s_valid/s_ready) carry one message byte and an end-of-message
//   flag; result requests (m_valid/m_ready) carry the delayed byte, '*' where a
//   keyword was masked, and on the final byte the filtered flag, byte count and
//   word count. cfg_valid/cfg_ready writes keywords 0..4 and the length word.
//   throughput is one byte per cycle while s_ready is high. each byte passes a
//   window of NUM_KEYWORDS*(MAX_KEYWORD_LEN-1)+1 stages (36 by default) with one
//   keyword matcher per stage span; inside a message a byte leaves the window once
//   NUM_KEYWORDS*(MAX_KEYWORD_LEN-1) later bytes have arrived. after the final
//   byte of a message the window drains on its own at one byte per cycle while
//   the queue has room; the next message may enter right behind it.
//   when the receiver stalls, the four-entry queue and the output register fill
//   first; s_ready drops while a byte waits at the window exit behind a full
//   queue. reset empties the window, queue and statistics and restores the
//   default keyword set; no clearing pass is needed.
`timescale 1ns / 1ps

module keyword_mask_filter
    import kmf_pkg::*;
#(
    parameter int NUM_KEYWORDS    = DEF_NUM_KEYWORDS,
    parameter int MAX_KEYWORD_LEN = DEF_MAX_KEYWORD_LEN
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KW_W-1:0]      cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [BYTE_W-1:0]    s_in_byte,
    input  logic                 s_in_last,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [BYTE_W-1:0]    m_out_byte,
    output logic                 m_out_last,
    output logic                 m_filtered,
    output logic [STAT_W-1:0]    m_byte_count,
    output logic [STAT_W-1:0]    m_word_total
);

    logic [NUM_KEYWORDS-1:0][KW_W-1:0]  kw_words;
    logic [NUM_KEYWORDS-1:0][LEN_W-1:0] kw_lens;
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_not_empty;
    kmf_entry_t q_in;
    kmf_entry_t q_out;

    kmf_cfg #(
        .NUM_KEYWORDS    (NUM_KEYWORDS),
        .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .kw_words  (kw_words),
        .kw_lens   (kw_lens)
    );

    kmf_front #(
        .NUM_KEYWORDS    (NUM_KEYWORDS),
        .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .kw_words  (kw_words),
        .kw_lens   (kw_lens),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .s_in_last (s_in_last),
        .q_push    (q_push),
        .q_entry   (q_in),
        .q_full    (q_full)
    );

    kmf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (q_out),
        .not_empty  (q_not_empty)
    );

    kmf_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_not_empty),
        .q_entry      (q_out),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_out_last   (m_out_last),
        .m_filtered   (m_filtered),
        .m_byte_count (m_byte_count),
        .m_word_total (m_word_total)
    );

endmodule

// File: tb/kmf_checker.sv
// checker for the keyword mask filter: predicts every result request and compares it
`timescale 1ns / 1ps

module kmf_checker
    import kmf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KW_W-1:0]      cfg_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [BYTE_W-1:0]    s_in_byte,
    input  logic                 s_in_last,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [BYTE_W-1:0]    m_out_byte,
    input  logic                 m_out_last,
    input  logic                 m_filtered,
    input  logic [STAT_W-1:0]    m_byte_count,
    input  logic [STAT_W-1:0]    m_word_total,
    output int                   fail_count,
    output int                   outstanding
);

    localparam int NKW  = DEF_NUM_KEYWORDS;
    localparam int KMAX = DEF_MAX_KEYWORD_LEN;
    localparam int SPAN = KMAX - 1;
    localparam int LAG  = NKW * SPAN;
    localparam int WIN  = LAG + 1;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              filt;
        logic [STAT_W-1:0] nbytes;
        logic [STAT_W-1:0] nwords;
    } out_beat_t;

    out_beat_t         due_beats [$];
    logic [KW_W-1:0]   kw_word [NKW];
    logic [LENS_W-1:0] kw_lens;
    logic [BYTE_W-1:0] raw_hist [WIN];
    logic [BYTE_W-1:0] low_hist [WIN];
    bit                mark_hist [WIN];
    int                held;
    int                skip_cnt [NKW];
    int unsigned       msg_bytes;
    int unsigned       msg_words;
    bit                mid_word;
    bit                hit_seen;

    function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] b);
        return (b inside {[8'h41:8'h5A]}) ? (b | 8'h20) : b;
    endfunction

    function automatic bit blank(input logic [BYTE_W-1:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic int kw_size(input int k);
        int n;
        n = int'(kw_lens[4*k +: 4]);
        return (n > KMAX) ? KMAX : n;
    endfunction

    function automatic void clear_message();
        for (int i = 0; i < WIN; i++) mark_hist[i] = 1'b0;
        for (int k = 0; k < NKW; k++) skip_cnt[k] = 0;
        held      = 0;
        msg_bytes = 0;
        msg_words = 0;
        mid_word  = 1'b0;
        hit_seen  = 1'b0;
    endfunction

    // keyword k tries a match whose first character sits at age a
    function automatic void try_mask(input int k, input int a);
        int n;
        int j;
        if (a >= held) return;
        if (skip_cnt[k] > 0) begin
            skip_cnt[k]--;
            return;
        end
        n = kw_size(k);
        if (n == 0 || a + 1 < n) return;
        for (j = 0; j < n; j++) begin
            if (low_hist[a-j] != to_lower(kw_word[k][8*j +: 8])) return;
        end
        for (j = 0; j < n; j++) begin
            mark_hist[a-j] = 1'b1;
            low_hist[a-j]  = STAR_BYTE;
        end
        skip_cnt[k] = n - 1;
        hit_seen    = 1'b1;
    endfunction

    function automatic void emit_beat(input int a, input bit fin);
        out_beat_t         r;
        logic [BYTE_W-1:0] b;
        b = mark_hist[a] ? STAR_BYTE : raw_hist[a];
        if (msg_bytes < STAT_MAX) msg_bytes++;
        if (blank(b)) begin
            mid_word = 1'b0;
        end else if (!mid_word) begin
            mid_word = 1'b1;
            if (msg_words < STAT_MAX) msg_words++;
        end
        r.data   = b;
        r.last   = fin;
        r.filt   = fin && hit_seen;
        r.nbytes = fin ? msg_bytes[STAT_W-1:0] : '0;
        r.nwords = fin ? msg_words[STAT_W-1:0] : '0;
        due_beats.push_back(r);
        outstanding++;
    endfunction

    function automatic void absorb_byte(input logic [BYTE_W-1:0] b, input bit fin);
        int i;
        int k;
        int a;
        for (i = WIN - 1; i > 0; i--) begin
            raw_hist[i]  = raw_hist[i-1];
            low_hist[i]  = low_hist[i-1];
            mark_hist[i] = mark_hist[i-1];
        end
        raw_hist[0]  = b;
        low_hist[0]  = to_lower(b);
        mark_hist[0] = 1'b0;
        if (held < WIN) held++;
        for (k = 0; k < NKW; k++) try_mask(k, (k + 1) * SPAN);
        if (!fin) begin
            if (held > LAG) begin
                emit_beat(LAG, 1'b0);
                held = LAG;
            end
        end else begin
            // end of message: every keyword finishes its scan, then the window flushes
            for (k = 0; k < NKW; k++) begin
                for (a = (k + 1) * SPAN - 1; a >= 0; a--) try_mask(k, a);
            end
            for (i = held - 1; i >= 0; i--) emit_beat(i, i == 0);
            clear_message();
        end
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        fail_count++;
        $display("%0t: mismatch on %s, got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    task automatic check_beat();
        out_beat_t w;
        if (due_beats.size() == 0) begin
            note_mismatch("unexpected result", m_out_byte, 0);
            return;
        end
        w = due_beats.pop_front();
        outstanding--;
        if (m_out_byte !== w.data) note_mismatch("out_byte", m_out_byte, w.data);
        if (m_out_last !== w.last) note_mismatch("out_last", m_out_last, w.last);
        if (m_filtered !== w.filt) note_mismatch("filtered", m_filtered, w.filt);
        if (m_byte_count !== w.nbytes) note_mismatch("byte_count", m_byte_count, w.nbytes);
        if (m_word_total !== w.nwords) note_mismatch("word_total", m_word_total, w.nwords);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            due_beats.delete();
            fail_count  = 0;
            outstanding = 0;
            for (int k = 0; k < NKW; k++) kw_word[k] = KW_RESET[k];
            kw_lens = LENS_RESET;
            clear_message();
        end else begin
            if (m_valid && m_ready) check_beat();
            if (cfg_valid && cfg_ready) begin
                if (cfg_index < CFG_IDX_LENGTHS) kw_word[cfg_index] = cfg_data;
                else if (cfg_index == CFG_IDX_LENGTHS) kw_lens = cfg_data[LENS_W-1:0];
            end
            if (s_valid && s_ready) absorb_byte(s_in_byte, s_in_last);
        end
    end

endmodule

// File: tb/tb_keyword_mask_filter.sv
// testbench top for the keyword mask filter: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_keyword_mask_filter;
    import kmf_pkg::*;

    localparam int NKW        = DEF_NUM_KEYWORDS;
    localparam int KMAX       = DEF_MAX_KEYWORD_LEN;
    localparam int SETTLE     = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_KW0      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_KW1      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_KW2      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_KW3      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_KW4      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [KW_W-1:0]      cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_in_byte = '0;
    logic                 s_in_last = 1'b0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [BYTE_W-1:0]    m_out_byte;
    logic                 m_out_last;
    logic                 m_filtered;
    logic [STAT_W-1:0]    m_byte_count;
    logic [STAT_W-1:0]    m_word_total;

    int                fail_count;
    int                outstanding;
    bit                idle_on     = 1'b1;
    int                stall_left  = 0;
    int unsigned       random_sent = 0;
    logic [KW_W-1:0]   kw_bank [NKW];
    logic [LENS_W-1:0] len_bank;
    logic [BYTE_W-1:0] msg_buf [$];

    keyword_mask_filter u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .s_in_last    (s_in_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_out_last   (m_out_last),
        .m_filtered   (m_filtered),
        .m_byte_count (m_byte_count),
        .m_word_total (m_word_total)
    );

    kmf_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .s_in_last    (s_in_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_out_last   (m_out_last),
        .m_filtered   (m_filtered),
        .m_byte_count (m_byte_count),
        .m_word_total (m_word_total),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("keyword_mask_filter test failed");
        $finish;
    end

    // receiver stalls in short bursts while idle_on is set
    always @(negedge aclk) begin
        if (!idle_on) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic int kw_span(input int k);
        int n;
        n = int'(len_bank[4*k +: 4]);
        return (n > KMAX) ? KMAX : n;
    endfunction

    function automatic logic [BYTE_W-1:0] filler_byte();
        case ($urandom_range(0, 13))
            0:       return "a";
            1:       return "b";
            2:       return "A";
            3:       return "B";
            4:       return " ";
            5:       return "*";
            6:       return 8'h09;
            7:       return 8'h0D;
            8:       return 8'h08;
            9:       return 8'h0E;
            10:      return 8'h40;
            11:      return 8'h5B;
            12:      return "Z";
            default: return "z";
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KW_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        if (idx < CFG_IDX_LENGTHS) kw_bank[idx] = val;
        else if (idx == CFG_IDX_LENGTHS) len_bank = val[LENS_W-1:0];
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic fin);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 3);
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_in_byte <= b;
        s_in_last <= fin;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_buf.size(); i++) push_byte(msg_buf[i], i == msg_buf.size() - 1);
        msg_buf.delete();
    endtask

    task automatic put_text(input string t);
        for (int i = 0; i < t.len(); i++) msg_buf.push_back(t[i]);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic add_keyword_text(input int k);
        logic [BYTE_W-1:0] b;
        for (int j = 0; j < kw_span(k); j++) begin
            b = kw_bank[k][8*j +: 8];
            if (((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) && $urandom_range(0, 1))
                b = b ^ 8'h20;
            msg_buf.push_back(b);
        end
    endtask

    task automatic make_message(input int target);
        int pick;
        int k;
        while (msg_buf.size() < target) begin
            pick = $urandom_range(0, 9);
            k    = $urandom_range(0, NKW - 1);
            if (pick < 3 && kw_span(k) > 0) add_keyword_text(k);
            else if (pick < 9) msg_buf.push_back(filler_byte());
            else msg_buf.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic random_phase(input int budget);
        int unsigned goal;
        int          n;
        goal = random_sent + budget;
        while (random_sent < goal) begin
            case ($urandom_range(0, 3))
                0:       n = $urandom_range(1, 6);
                3:       n = $urandom_range(36, 80);
                default: n = $urandom_range(7, 35);
            endcase
            if (n > int'(goal - random_sent)) n = int'(goal - random_sent);
            make_message(n);
            random_sent += msg_buf.size();
            send_message();
            if ($urandom_range(0, 5) == 0) wait_idle();
        end
    endtask

    task automatic scramble_keywords();
        logic [KW_W-1:0]   w;
        logic [LENS_W-1:0] lens;
        int                n;
        lens = '0;
        for (int k = 0; k < NKW; k++) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
            lens[4*k +: 4] = 4'(n);
            w = {$urandom, $urandom};
            for (int j = 0; j < n && j < KMAX; j++) w[8*j +: 8] = filler_byte();
            write_reg(CFG_IDX_W'(k), w);
        end
        write_reg(CFG_IDX_LENGTHS, {$urandom, 12'($urandom), lens});
        if ($urandom_range(0, 1))
            write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE_LO : CFG_IDX_SPARE_HI,
                      {$urandom, $urandom});
    endtask

    initial begin
        for (int k = 0; k < NKW; k++) kw_bank[k] = KW_RESET[k];
        len_bank = LENS_RESET;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // default keywords: byte extremes, fold edges, short messages
        msg_buf.push_back(8'h00);
        send_message();
        msg_buf.push_back(8'hFF);
        send_message();
        put_text("@Z[");
        msg_buf.push_back(8'h09);
        put_text("Ass bitch");
        msg_buf.push_back(8'h0D);
        send_message();
        random_phase(50);
        wait_idle();

        // register extremes, oversized lengths, disabled keyword, unused indexes
        write_reg(CFG_IDX_KW0, '0);
        write_reg(CFG_IDX_KW1, '1);
        write_reg(CFG_IDX_KW2, 64'h2A2A_2A2A_2A2A_2A2A);
        write_reg(CFG_IDX_KW3, 64'h4847_4645_4443_4241);
        write_reg(CFG_IDX_KW4, {$urandom, $urandom});
        write_reg(CFG_IDX_LENGTHS, {44'h0, 4'd0, 4'd9, 4'd2, 4'd8, 4'd15});
        write_reg(CFG_IDX_SPARE_LO, '1);
        write_reg(CFG_IDX_SPARE_HI, {$urandom, $urandom});
        repeat (8) msg_buf.push_back(8'h00);
        put_text("aBcDeFgH");
        send_message();
        wait_idle();

        write_reg(CFG_IDX_LENGTHS, '0);
        random_phase(20);
        wait_idle();
        write_reg(CFG_IDX_LENGTHS, '1);
        random_phase(20);
        wait_idle();

        for (int p = 0; p < 4; p++) begin
            idle_on = (p != 2);
            scramble_keywords();
            random_phase(20);
            wait_idle();
        end

        // last part runs without idling
        idle_on = 1'b0;
        scramble_keywords();
        random_phase(55);
        wait_idle();

        if (fail_count == 0 && outstanding == 0) $display("keyword_mask_filter test passed");
        else $display("keyword_mask_filter test failed");
        $finish;
    end

endmodule
